@@ rtl/kbs_pkg.sv @@
// ---------------------------------------------------------------------------
// kbs_pkg
// Shared types, constants and helpers of the spline point generator.
// ---------------------------------------------------------------------------
package kbs_pkg;

    localparam int KBS_POINTS_DEFAULT = 32;
    localparam int KBS_QUEUE_DEPTH    = 2;
    localparam int KBS_Q14_ONE        = 16384;

    typedef struct packed {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [15:0] t;
        logic signed [15:0] b;
        logic signed [15:0] c;
    } t_knot;

    // one segment job: neighbors a and d, end points b and c
    typedef struct packed {
        t_knot a;
        t_knot b;
        t_knot c;
        t_knot d;
        logic  last;
    } t_job;

    function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
        logic signed [23:0] r;
        if (v > 48'sd8388607) begin
            r = 24'sd8388607;
        end else if (v < -48'sd8388608) begin
            r = -24'sd8388608;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/kbs_knot_if.sv @@
// ---------------------------------------------------------------------------
// kbs_knot_if
// Knot channel: valid/ready handshake with one knot word.
// ---------------------------------------------------------------------------
interface kbs_knot_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] knot_x;
    logic signed [23:0] knot_y;
    logic signed [15:0] tension;
    logic signed [15:0] bias;
    logic signed [15:0] continuity;
    logic               last_knot;

    modport source (output valid, knot_x, knot_y, tension, bias, continuity, last_knot,
                    input ready);
    modport sink   (input valid, knot_x, knot_y, tension, bias, continuity, last_knot,
                    output ready);
endinterface

@@ rtl/kbs_point_if.sv @@
// ---------------------------------------------------------------------------
// kbs_point_if
// Point channel: valid/ready handshake with one curve point word.
// ---------------------------------------------------------------------------
interface kbs_point_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] point_x;
    logic signed [23:0] point_y_flipped;
    logic               last_point;

    modport source (output valid, point_x, point_y_flipped, last_point, input ready);
    modport sink   (input valid, point_x, point_y_flipped, last_point, output ready);
endinterface

@@ rtl/kbs_front.sv @@
// ---------------------------------------------------------------------------
// kbs_front
// Accept knots, keep the three-knot window, issue segment jobs.
// ---------------------------------------------------------------------------
module kbs_front
    import kbs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    kbs_knot_if.sink  i_knot,
    output logic      o_job_valid,
    input  logic      i_job_ready,
    output t_job      o_job
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_J1   = 2'd1;
    localparam logic [1:0] F_J2   = 2'd2;

    logic [1:0] r_fstate, n_fstate;
    logic [1:0] r_seen;
    t_knot      r_win [3];
    t_knot      r_new;
    logic       r_nlast;

    t_knot w_in;
    logic  w_acc, w_push, w_fin, w_fin_last;
    t_knot w_fin_knot;
    t_job  w_j1, w_j2;

    assign w_in = '{x: i_knot.knot_x, y: i_knot.knot_y, t: i_knot.tension,
                    b: i_knot.bias, c: i_knot.continuity};
    assign i_knot.ready = (r_fstate == F_IDLE);
    assign w_acc  = i_knot.valid && i_knot.ready;
    assign w_push = o_job_valid && i_job_ready;

    always_comb begin
        w_j1 = '{a: (r_seen == 2'd3) ? r_win[0] : r_win[1], b: r_win[1], c: r_win[2],
                 d: r_new, last: !r_nlast};
        w_j2 = '{a: (r_seen >= 2'd2) ? r_win[1] : r_win[2], b: r_win[2], c: r_new,
                 d: r_new, last: 1'b1};
    end

    assign o_job_valid = (r_fstate != F_IDLE);
    assign o_job       = (r_fstate == F_J1) ? w_j1 : w_j2;

    always_comb begin
        n_fstate   = r_fstate;
        w_fin      = 1'b0;
        w_fin_knot = r_new;
        w_fin_last = r_nlast;
        case (r_fstate)
            F_IDLE: begin
                if (w_acc) begin
                    if (r_seen >= 2'd2) begin
                        n_fstate = F_J1;
                    end else if (i_knot.last_knot && r_seen == 2'd1) begin
                        n_fstate = F_J2;
                    end else begin
                        w_fin      = 1'b1;
                        w_fin_knot = w_in;
                        w_fin_last = i_knot.last_knot;
                    end
                end
            end
            F_J1: begin
                if (w_push) begin
                    if (r_nlast) begin
                        n_fstate = F_J2;
                    end else begin
                        n_fstate = F_IDLE;
                        w_fin    = 1'b1;
                    end
                end
            end
            F_J2: begin
                if (w_push) begin
                    n_fstate = F_IDLE;
                    w_fin    = 1'b1;
                end
            end
            default: n_fstate = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fstate <= F_IDLE;
            r_seen   <= 2'd0;
        end else begin
            r_fstate <= n_fstate;
            if (w_fin) begin
                if (w_fin_last) begin
                    r_seen <= 2'd0;
                end else if (r_seen != 2'd3) begin
                    r_seen <= r_seen + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_new   <= w_in;
            r_nlast <= i_knot.last_knot;
        end
        if (w_fin && !w_fin_last) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= w_fin_knot;
        end
    end

    a_j2_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fstate == F_J2 |-> r_nlast)
        else $error("closing segment without a final knot");
    a_j1_needs_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fstate == F_J1 |-> r_seen >= 2'd2)
        else $error("segment issued with fewer than two stored knots");
    a_fin_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fin |=> r_fstate == F_IDLE)
        else $error("window updated while jobs pending");

endmodule

@@ rtl/kbs_queue.sv @@
// ---------------------------------------------------------------------------
// kbs_queue
// Short job queue between knot front and point engine.
// ---------------------------------------------------------------------------
module kbs_queue
    import kbs_pkg::*;
#(
    parameter int DEPTH = KBS_QUEUE_DEPTH
)(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_job i_push_data,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_job o_pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          w_push, w_pop;

    assign o_push_ready = (r_cnt != CW'(DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_data   = r_mem[r_rp];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (w_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            r_cnt <= r_cnt + CW'(w_push) - CW'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

endmodule

@@ rtl/kbs_engine.sv @@
// ---------------------------------------------------------------------------
// kbs_engine
// Segment engine: tangent weights, tangents, Hermite points on one multiplier.
// ---------------------------------------------------------------------------
module kbs_engine
    import kbs_pkg::*;
#(
    parameter int POINTS_PER_SEGMENT = KBS_POINTS_DEFAULT
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_job_valid,
    output logic        o_job_ready,
    input  t_job        i_job,
    kbs_point_if.source o_point
);

    localparam int N  = POINTS_PER_SEGMENT;
    localparam int LW = (N > 1) ? $clog2(N) : 1;
    localparam longint NN = N;
    localparam longint N3 = NN * NN * NN;
    localparam longint QQ = KBS_Q14_ONE;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SET  = 2'd1;
    localparam logic [1:0] S_PNT  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    // Hermite weights, round-to-nearest of Q14 * basis(l/N)
    logic signed [15:0] w_h1 [N];
    logic signed [15:0] w_h2 [N];
    logic signed [15:0] w_h3 [N];
    logic signed [15:0] w_h4 [N];

    for (genvar g = 0; g < N; g++) begin : g_herm
        localparam longint L1 = g;
        localparam longint L2 = L1 * L1;
        localparam longint L3 = L2 * L1;
        localparam longint X1 = 2 * QQ * (2 * L3 - 3 * L2 * NN + N3) + N3;
        localparam longint X2 = 2 * QQ * (3 * L2 * NN - 2 * L3) + N3;
        localparam longint X3 = 2 * QQ * (L3 - 2 * L2 * NN + L1 * NN * NN) + N3;
        localparam longint X4 = 2 * QQ * (L3 - L2 * NN) + N3;
        localparam longint H1 = X1 / (2 * N3);
        localparam longint H2 = X2 / (2 * N3);
        localparam longint H3 = X3 / (2 * N3);
        localparam longint H4 = (X4 >= 0) ? X4 / (2 * N3)
                                          : -((-X4 + 2 * N3 - 1) / (2 * N3));
        assign w_h1[g] = 16'(H1);
        assign w_h2[g] = 16'(H2);
        assign w_h3[g] = 16'(H3);
        assign w_h4[g] = 16'(H4);
    end

    logic [1:0]         r_state;
    t_job               r_job;
    logic [3:0]         r_step;
    logic               r_phase;
    logic [3:0]         r_pstep;
    logic [LW-1:0]      r_lidx;
    logic signed [18:0] r_tmp;
    logic signed [18:0] r_w   [4];
    logic signed [29:0] r_tan [4];
    logic signed [47:0] r_acc, r_accx, r_accy;
    logic signed [54:0] r_prod;
    logic               r_ovalid, r_olast;
    logic signed [23:0] r_ox, r_oy;

    logic signed [17:0] w_bt_m, w_bb_p, w_bb_m, w_bc_p, w_bc_m;
    logic signed [17:0] w_ct_m, w_cb_p, w_cb_m, w_cc_p, w_cc_m;
    logic signed [24:0] w_dbax, w_dcbx, w_ddcx, w_dbay, w_dcby, w_ddcy;
    logic signed [29:0] w_mul_a;
    logic signed [24:0] w_mul_b;
    logic signed [54:0] w_r14, w_r15;
    logic signed [47:0] w_tsum, w_trnd, w_pacc, w_rx, w_ry;
    logic [2:0]         w_ps;
    logic               w_pop, w_out_free, w_load, w_last_pt;

    assign w_bt_m = 18'sd16384 - 18'(r_job.b.t);
    assign w_bb_p = 18'sd16384 + 18'(r_job.b.b);
    assign w_bb_m = 18'sd16384 - 18'(r_job.b.b);
    assign w_bc_p = 18'sd16384 + 18'(r_job.b.c);
    assign w_bc_m = 18'sd16384 - 18'(r_job.b.c);
    assign w_ct_m = 18'sd16384 - 18'(r_job.c.t);
    assign w_cb_p = 18'sd16384 + 18'(r_job.c.b);
    assign w_cb_m = 18'sd16384 - 18'(r_job.c.b);
    assign w_cc_p = 18'sd16384 + 18'(r_job.c.c);
    assign w_cc_m = 18'sd16384 - 18'(r_job.c.c);

    assign w_dbax = 25'(r_job.b.x) - 25'(r_job.a.x);
    assign w_dcbx = 25'(r_job.c.x) - 25'(r_job.b.x);
    assign w_ddcx = 25'(r_job.d.x) - 25'(r_job.c.x);
    assign w_dbay = 25'(r_job.b.y) - 25'(r_job.a.y);
    assign w_dcby = 25'(r_job.c.y) - 25'(r_job.b.y);
    assign w_ddcy = 25'(r_job.d.y) - 25'(r_job.c.y);

    // operand select for the shared multiplier
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        if (r_state == S_SET) begin
            case (r_step)
                4'd0:  begin w_mul_a = 30'(w_bt_m); w_mul_b = 25'(w_bb_p); end
                4'd1:  begin w_mul_a = 30'(r_tmp);  w_mul_b = 25'(w_bc_p); end
                4'd2:  begin w_mul_a = 30'(w_bt_m); w_mul_b = 25'(w_bb_m); end
                4'd3:  begin w_mul_a = 30'(r_tmp);  w_mul_b = 25'(w_bc_m); end
                4'd4:  begin w_mul_a = 30'(w_ct_m); w_mul_b = 25'(w_cb_p); end
                4'd5:  begin w_mul_a = 30'(r_tmp);  w_mul_b = 25'(w_cc_m); end
                4'd6:  begin w_mul_a = 30'(w_ct_m); w_mul_b = 25'(w_cb_m); end
                4'd7:  begin w_mul_a = 30'(r_tmp);  w_mul_b = 25'(w_cc_p); end
                4'd8:  begin w_mul_a = 30'(r_w[0]); w_mul_b = w_dbax; end
                4'd9:  begin w_mul_a = 30'(r_w[1]); w_mul_b = w_dcbx; end
                4'd10: begin w_mul_a = 30'(r_w[0]); w_mul_b = w_dbay; end
                4'd11: begin w_mul_a = 30'(r_w[1]); w_mul_b = w_dcby; end
                4'd12: begin w_mul_a = 30'(r_w[2]); w_mul_b = w_dcbx; end
                4'd13: begin w_mul_a = 30'(r_w[3]); w_mul_b = w_ddcx; end
                4'd14: begin w_mul_a = 30'(r_w[2]); w_mul_b = w_dcby; end
                default: begin w_mul_a = 30'(r_w[3]); w_mul_b = w_ddcy; end
            endcase
        end else if (r_state == S_PNT) begin
            case (r_pstep)
                4'd0: begin w_mul_a = 30'(r_job.b.x); w_mul_b = 25'(w_h1[r_lidx]); end
                4'd1: begin w_mul_a = 30'(r_job.c.x); w_mul_b = 25'(w_h2[r_lidx]); end
                4'd2: begin w_mul_a = r_tan[0];       w_mul_b = 25'(w_h3[r_lidx]); end
                4'd3: begin w_mul_a = r_tan[2];       w_mul_b = 25'(w_h4[r_lidx]); end
                4'd4: begin w_mul_a = 30'(r_job.b.y); w_mul_b = 25'(w_h1[r_lidx]); end
                4'd5: begin w_mul_a = 30'(r_job.c.y); w_mul_b = 25'(w_h2[r_lidx]); end
                4'd6: begin w_mul_a = r_tan[1];       w_mul_b = 25'(w_h3[r_lidx]); end
                4'd7: begin w_mul_a = r_tan[3];       w_mul_b = 25'(w_h4[r_lidx]); end
                default: begin w_mul_a = '0; w_mul_b = '0; end
            endcase
        end
    end

    assign w_r14  = (r_prod + 55'sd8192) >>> 14;
    assign w_r15  = (r_prod + 55'sd16384) >>> 15;
    assign w_tsum = 48'(r_prod) + r_acc;
    assign w_trnd = (w_tsum + 48'sd8192) >>> 14;
    assign w_ps   = 3'(r_pstep - 4'd1);
    assign w_pacc = 48'(r_prod);
    assign w_rx   = (r_accx + 48'sd8192) >>> 14;
    assign w_ry   = -((r_accy + 48'sd8192) >>> 14);

    assign o_job_ready = (r_state == S_IDLE);
    assign w_pop       = i_job_valid && o_job_ready;
    assign w_out_free  = !r_ovalid || o_point.ready;
    assign w_load      = (r_state == S_OUT) && w_out_free;
    assign w_last_pt   = (r_lidx == LW'(N - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_phase  <= 1'b0;
            r_pstep  <= '0;
            r_lidx   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (o_point.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_pop) begin
                        r_state <= S_SET;
                        r_step  <= '0;
                        r_phase <= 1'b0;
                    end
                end
                S_SET: begin
                    r_phase <= !r_phase;
                    if (r_phase) begin
                        r_step <= r_step + 4'd1;
                        if (r_step == 4'd15) begin
                            r_state <= S_PNT;
                            r_pstep <= '0;
                            r_lidx  <= '0;
                        end
                    end
                end
                S_PNT: begin
                    r_pstep <= r_pstep + 4'd1;
                    if (r_pstep == 4'd8) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        if (w_last_pt) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_lidx  <= r_lidx + LW'(1);
                            r_pstep <= '0;
                            r_state <= S_PNT;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath: product register, consumed in the cycle after it is formed
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
        if (w_pop) begin
            r_job <= i_job;
        end
        if (r_state == S_SET && r_phase) begin
            if (!r_step[3]) begin
                if (!r_step[0]) begin
                    r_tmp <= w_r14[18:0];
                end else begin
                    r_w[r_step[2:1]] <= w_r15[18:0];
                end
            end else begin
                if (!r_step[0]) begin
                    r_acc <= w_pacc;
                end else begin
                    r_tan[r_step[2:1]] <= w_trnd[29:0];
                end
            end
        end
        if (r_state == S_PNT && r_pstep != 4'd0) begin
            if (!w_ps[2]) begin
                r_accx <= (w_ps[1:0] == 2'd0) ? w_pacc : r_accx + w_pacc;
            end else begin
                r_accy <= (w_ps[1:0] == 2'd0) ? w_pacc : r_accy + w_pacc;
            end
        end
        if (w_load) begin
            r_ox    <= sat24(w_rx);
            r_oy    <= sat24(w_ry);
            r_olast <= r_job.last && w_last_pt;
        end
    end

    assign o_point.valid           = r_ovalid;
    assign o_point.point_x         = r_ox;
    assign o_point.point_y_flipped = r_oy;
    assign o_point.last_point      = r_olast;

    a_pstep_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PNT |-> r_pstep <= 4'd8)
        else $error("point step out of range");
    a_pop_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> r_state == S_SET && r_step == 4'd0 && !r_phase)
        else $error("job taken without starting setup");
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> r_ovalid && (r_olast == $past(r_job.last && w_last_pt)))
        else $error("point word not presented after load");

endmodule

@@ rtl/kb_spline_point_generator_top.sv @@
// ---------------------------------------------------------------------------
// kb_spline_point_generator_top
// Kochanek-Bartels spline point generator, fixed point, streaming knots.
// ---------------------------------------------------------------------------
// Usage:
//   i_knot carries one knot word per handshake (x, y Q16.8; tension, bias,
//   continuity Q1.14; last_knot). o_point carries curve point words (x and
//   negated y, Q16.8, saturated) with last_point on the final word that a
//   knot causes. Both channels use valid/ready.
//   From the second stored knot on, every knot releases one segment of
//   POINTS_PER_SEGMENT words; a final knot releases the pending segment and
//   the closing one, then the window returns to empty for the next curve.
//   Each segment runs on the single shared multiplier: 16 setup products
//   for weights and tangents, then 8 products and one output word per
//   point. The engine takes a new segment job only when idle, after the
//   last point word of the current one has been loaded.
//   The knot front and the point engine meet in a two-entry job queue, so
//   knots keep coming in while the engine works. A stalled receiver holds
//   the output word; the engine waits, then the queue fills, then i_knot
//   drops ready. Reset (synchronous, active low) empties window and queue.
// ---------------------------------------------------------------------------
module kb_spline_point_generator_top
    import kbs_pkg::*;
#(
    parameter int POINTS_PER_SEGMENT = KBS_POINTS_DEFAULT
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    kbs_knot_if.sink    i_knot,
    kbs_point_if.source o_point
);

    // front to queue
    logic f_valid, f_ready;
    t_job f_job;
    // queue to engine
    logic q_valid, q_ready;
    t_job q_job;

    kbs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_knot      (i_knot),
        .o_job_valid (f_valid),
        .i_job_ready (f_ready),
        .o_job       (f_job)
    );

    kbs_queue #(
        .DEPTH (KBS_QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_data  (f_job),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_data   (q_job)
    );

    kbs_engine #(
        .POINTS_PER_SEGMENT (POINTS_PER_SEGMENT)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .o_job_ready (q_ready),
        .i_job       (q_job),
        .o_point     (o_point)
    );

endmodule

@@ tb/kb_spline_point_generator_top_tb.sv @@
// ---------------------------------------------------------------------------
// kb_spline_point_generator_top_tb
// Self-checking bench: streams knot curves into the point generator and
// compares every point word with a fixed-point Hermite predictor.
// ---------------------------------------------------------------------------
module kb_spline_point_generator_top_tb;
    import kbs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  NPTS       = 32;
    localparam int  WDOG_LIMIT = 20000;
    localparam int  DRAIN_WAIT = 800;
    localparam int  N_RANDOM   = 460;

    typedef struct {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic               last;
    } t_point;

    // directed row: one knot, plus a typed first point where it is obvious
    typedef struct {
        t_knot              k;
        logic               last;
        bit                 has_exp;
        logic signed [23:0] exp_x;
        logic signed [23:0] exp_y;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    kbs_knot_if  knot_if();
    kbs_point_if point_if();

    kb_spline_point_generator_top #(.POINTS_PER_SEGMENT(NPTS)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_knot  (knot_if),
        .o_point (point_if)
    );

    always #5 i_clk = ~i_clk;

    // predictor state: knot window (index 2 newest) and fill level
    t_knot  win[3];
    int     win_fill;
    t_point pending_points[$];

    int  err_count;
    int  send_idle;
    int  recv_idle;
    bit  sending;
    int  quiet_cycles;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    function automatic longint floor_div(input longint n, input longint d);
        if (n >= 0) return n / d;
        return -((-n + d - 1) / d);
    endfunction

    // round to nearest, ties toward plus infinity
    function automatic longint round_div(input longint n, input longint d);
        return floor_div(2 * n + d, 2 * d);
    endfunction

    function automatic longint round_shift(input longint v, input int s);
        return round_div(v, longint'(1) << s);
    endfunction

    function automatic longint shape_weight(input longint f1, input longint f2, input longint f3);
        return round_shift(round_shift(f1 * f2, 14) * f3, 15);
    endfunction

    function automatic logic signed [23:0] clip24(input longint v);
        if (v > 8388607) return 24'sd8388607;
        if (v < -8388608) return -24'sd8388608;
        return v[23:0];
    endfunction

    // append the points of segment b..c, shaped by neighbors a and d
    task automatic hermite_segment(input t_knot a, input t_knot b, input t_knot c, input t_knot d);
        longint o1, o2, i1, i2, tox, toy, tix, tiy;
        longint n3, l2, l3, h1, h2, h3, h4;
        t_point p;
        o1 = shape_weight(KBS_Q14_ONE - b.t, KBS_Q14_ONE + b.b, KBS_Q14_ONE + b.c);
        o2 = shape_weight(KBS_Q14_ONE - b.t, KBS_Q14_ONE - b.b, KBS_Q14_ONE - b.c);
        i1 = shape_weight(KBS_Q14_ONE - c.t, KBS_Q14_ONE + c.b, KBS_Q14_ONE - c.c);
        i2 = shape_weight(KBS_Q14_ONE - c.t, KBS_Q14_ONE - c.b, KBS_Q14_ONE + c.c);
        tox = round_shift(o1 * (longint'(b.x) - a.x) + o2 * (longint'(c.x) - b.x), 14);
        toy = round_shift(o1 * (longint'(b.y) - a.y) + o2 * (longint'(c.y) - b.y), 14);
        tix = round_shift(i1 * (longint'(c.x) - b.x) + i2 * (longint'(d.x) - c.x), 14);
        tiy = round_shift(i1 * (longint'(c.y) - b.y) + i2 * (longint'(d.y) - c.y), 14);
        n3 = NPTS * NPTS * NPTS;
        for (longint l = 0; l < NPTS; l++) begin
            l2 = l * l;
            l3 = l2 * l;
            h1 = round_div(KBS_Q14_ONE * (2 * l3 - 3 * l2 * NPTS + n3), n3);
            h2 = round_div(KBS_Q14_ONE * (3 * l2 * NPTS - 2 * l3), n3);
            h3 = round_div(KBS_Q14_ONE * (l3 - 2 * l2 * NPTS + l * NPTS * NPTS), n3);
            h4 = round_div(KBS_Q14_ONE * (l3 - l2 * NPTS), n3);
            p.x = clip24(round_shift(b.x * h1 + c.x * h2 + tox * h3 + tix * h4, 14));
            p.y = clip24(-round_shift(b.y * h1 + c.y * h2 + toy * h3 + tiy * h4, 14));
            p.last = 1'b0;
            pending_points.insert(pending_points.size(), p);
        end
    endtask

    // advance the predictor by one accepted knot word
    task automatic predict_knot(input t_knot k, input logic last);
        t_knot kk[4];
        int    n;
        int    base;
        n = 0;
        base = pending_points.size();
        for (int i = 3 - win_fill; i < 3; i++) begin
            kk[n] = win[i];
            n++;
        end
        kk[n] = k;
        n++;
        // pending segment: its D is the knot just arrived
        if (n >= 3)
            hermite_segment(kk[(n - 3) > 0 ? n - 4 : 0], kk[n - 3], kk[n - 2], kk[n - 1]);
        // closing segment: D clamped to the final knot
        if (last && n >= 2)
            hermite_segment(kk[(n - 2) > 0 ? n - 3 : 0], kk[n - 2], kk[n - 1], kk[n - 1]);
        if (pending_points.size() > base)
            pending_points[pending_points.size() - 1].last = 1'b1;
        if (last) begin
            for (int i = 0; i < 3; i++) win[i] = '0;
            win_fill = 0;
        end else begin
            win[0] = win[1];
            win[1] = win[2];
            win[2] = k;
            if (win_fill < 3) win_fill++;
        end
    endtask

    // send one knot word; the accept edge feeds the predictor
    task automatic send_knot(input t_knot k, input logic last, output int first_idx);
        while ($urandom_range(99) < send_idle) begin
            knot_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        knot_if.valid      <= 1'b1;
        knot_if.knot_x     <= k.x;
        knot_if.knot_y     <= k.y;
        knot_if.tension    <= k.t;
        knot_if.bias       <= k.b;
        knot_if.continuity <= k.c;
        knot_if.last_knot  <= last;
        @(posedge i_clk);
        while (!knot_if.ready) @(posedge i_clk);
        first_idx = pending_points.size();
        predict_knot(k, last);
    endtask

    function automatic t_knot random_knot();
        t_knot k;
        int    sel;
        sel = $urandom_range(99);
        if (sel < 12) begin
            k.x = 24'($urandom);
            k.y = 24'($urandom);
        end else begin
            k.x = 24'($urandom_range(131072) - 65536);
            k.y = 24'($urandom_range(131072) - 65536);
        end
        if (sel >= 95) begin
            k.t = ($urandom_range(1)) ? 16'sd16384 : -16'sd16384;
            k.b = ($urandom_range(1)) ? 16'sd16384 : -16'sd16384;
            k.c = ($urandom_range(1)) ? 16'sd16384 : -16'sd16384;
        end else begin
            k.t = 16'($urandom_range(32768) - 16384);
            k.b = 16'($urandom_range(32768) - 16384);
            k.c = 16'($urandom_range(32768) - 16384);
        end
        return k;
    endfunction

    // receiver: random ready, compare each accepted point word
    always @(posedge i_clk) begin
        t_point want;
        if (i_rst_n && point_if.valid && point_if.ready) begin
            if (pending_points.size() == 0) begin
                report_mismatch("unexpected point x", point_if.point_x, 0);
            end else begin
                want = pending_points.pop_front();
                if (point_if.point_x !== want.x)
                    report_mismatch("point_x", point_if.point_x, want.x);
                if (point_if.point_y_flipped !== want.y)
                    report_mismatch("point_y_flipped", point_if.point_y_flipped, want.y);
                if (point_if.last_point !== want.last)
                    report_mismatch("last_point", point_if.last_point, want.last);
            end
        end
        point_if.ready <= ($urandom_range(99) >= recv_idle);
    end

    // watchdog: count busy cycles in which no word moves
    always @(posedge i_clk) begin
        if ((knot_if.valid && knot_if.ready) || (point_if.valid && point_if.ready)
                || (!sending && pending_points.size() == 0)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WDOG_LIMIT) begin
                $display("watchdog expired at %0t", $realtime);
                $display("[kb_spline_point_generator_top] ERROR");
                $finish;
            end
        end
    end

    t_row rows[$];

    task automatic add_row(input int x, input int y, input int t, input int b, input int c,
                           input logic last, input bit has_exp, input int ex, input int ey);
        t_row r;
        r.k.x = 24'(x);
        r.k.y = 24'(y);
        r.k.t = 16'(t);
        r.k.b = 16'(b);
        r.k.c = 16'(c);
        r.last = last;
        r.has_exp = has_exp;
        r.exp_x = 24'(ex);
        r.exp_y = 24'(ey);
        rows.insert(rows.size(), r);
    endtask

    initial begin
        int    idx;
        int    phase;
        t_knot k;
        knot_if.valid      = 1'b0;
        knot_if.knot_x     = '0;
        knot_if.knot_y     = '0;
        knot_if.tension    = '0;
        knot_if.bias       = '0;
        knot_if.continuity = '0;
        knot_if.last_knot  = 1'b0;
        point_if.ready     = 1'b0;
        err_count = 0;
        win_fill = 0;
        for (int i = 0; i < 3; i++) win[i] = '0;
        send_idle = 26;
        recv_idle = 58;
        sending = 1'b1;
        quiet_cycles = 0;

        // single-knot curve: emits nothing
        add_row(1000, 2000, 0, 0, 0, 1'b1, 0, 0, 0);
        // two-knot curves: first point is knot B, y negated (and saturated)
        add_row(8388607, -8388608, 0, 0, 0, 1'b0, 0, 0, 0);
        add_row(-8388608, 8388607, 0, 0, 0, 1'b1, 1, 8388607, 8388607);
        add_row(-8388608, 8388607, -16384, 16384, -16384, 1'b0, 0, 0, 0);
        add_row(0, 0, 16384, -16384, 16384, 1'b1, 1, -8388608, -8388607);
        // zigzag at full scale with shape extremes: tangent overflow, saturation
        add_row(8388607, 8388607, -16384, 16384, 16384, 1'b0, 0, 0, 0);
        add_row(-8388608, -8388608, -16384, -16384, -16384, 1'b0, 0, 0, 0);
        add_row(8388607, 8388607, -16384, 16384, -16384, 1'b0, 0, 0, 0);
        add_row(-8388608, -8388608, -16384, -16384, 16384, 1'b0, 0, 0, 0);
        add_row(8388607, -8388608, 16384, 0, 0, 1'b1, 0, 0, 0);
        // ordinary curve, neutral shape, then mixed shape values
        add_row(0, 0, 0, 0, 0, 1'b0, 0, 0, 0);
        add_row(2560, 1280, 0, 0, 0, 1'b0, 0, 0, 0);
        add_row(5120, -1280, 8192, -8192, 4096, 1'b0, 0, 0, 0);
        add_row(7680, 640, -8192, 8192, -4096, 1'b0, 0, 0, 0);
        add_row(-256, -256, 16384, 16384, 16384, 1'b1, 0, 0, 0);
        add_row(1, -1, -1, 1, -1, 1'b0, 0, 0, 0);
        add_row(-1, 1, 1, -1, 1, 1'b1, 0, 0, 0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            send_knot(rows[i].k, rows[i].last, idx);
            if (rows[i].has_exp) begin
                if (pending_points.size() <= idx)
                    report_mismatch("typed point missing", 0, rows[i].exp_x);
                else if (pending_points[idx].x !== rows[i].exp_x
                         || pending_points[idx].y !== rows[i].exp_y)
                    report_mismatch("typed first x", pending_points[idx].x, rows[i].exp_x);
            end
        end

        for (phase = 0; phase < 3; phase++) begin
            // hold off the sender until every point of the last phase is out
            knot_if.valid <= 1'b0;
            while (pending_points.size() > 0) @(posedge i_clk);
            send_idle = (phase == 0) ? 26 : (phase == 1) ? 58 : 0;
            recv_idle = (phase == 0) ? 58 : (phase == 1) ? 26 : 0;
            for (int n = 0; n < N_RANDOM / 3; n++) begin
                k = random_knot();
                send_knot(k, ($urandom_range(3) == 0), idx);
            end
        end
        // close any open curve
        send_knot('0, 1'b1, idx);
        knot_if.valid <= 1'b0;
        sending = 1'b0;

        while (pending_points.size() > 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (err_count == 0 && pending_points.size() == 0) begin
            $display("[kb_spline_point_generator_top] OK");
        end else begin
            $display("[kb_spline_point_generator_top] ERROR");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/kbs_pkg.sv
rtl/kbs_knot_if.sv
rtl/kbs_point_if.sv
rtl/kbs_front.sv
rtl/kbs_queue.sv
rtl/kbs_engine.sv
rtl/kb_spline_point_generator_top.sv
tb/kb_spline_point_generator_top_tb.sv
